>>> rtl/core/grem_pkg.sv
// constants, types and slot tables shared by the gamepad report event mapper
`timescale 1ns / 1ps

package grem_pkg;

  // report layouts (func field)
  localparam logic [1:0] LAYOUT_PLAIN  = 2'd0;
  localparam logic [1:0] LAYOUT_HAT_A  = 2'd1;
  localparam logic [1:0] LAYOUT_HAT_B  = 2'd2;
  localparam logic [1:0] LAYOUT_UNUSED = 2'd3;
  localparam int         NUM_LAYOUTS   = 3;

  // minimum report lengths
  localparam logic [6:0] MIN_LEN_SHORT = 7'd7;
  localparam logic [6:0] MIN_LEN_LONG  = 7'd9;

  // stick thresholds
  localparam logic [7:0] AXIS_LOW  = 8'h40;
  localparam logic [7:0] AXIS_HIGH = 8'hC0;

  // hat nibble codes
  localparam logic [3:0] HAT_N  = 4'd0;
  localparam logic [3:0] HAT_NE = 4'd1;
  localparam logic [3:0] HAT_E  = 4'd2;
  localparam logic [3:0] HAT_SE = 4'd3;
  localparam logic [3:0] HAT_S  = 4'd4;
  localparam logic [3:0] HAT_SW = 4'd5;
  localparam logic [3:0] HAT_W  = 4'd6;
  localparam logic [3:0] HAT_NW = 4'd7;

  // held control bit positions
  localparam int CTRL_UP     = 0;
  localparam int CTRL_DOWN   = 1;
  localparam int CTRL_LEFT   = 2;
  localparam int CTRL_RIGHT  = 3;
  localparam int CTRL_FIRE   = 4;
  localparam int CTRL_ALT    = 5;
  localparam int CTRL_START  = 6;
  localparam int CTRL_SELECT = 7;
  localparam int NUM_CTRLS   = 8;

  // extra button bit positions
  localparam int EXTRA_X    = 0;
  localparam int EXTRA_Y    = 1;
  localparam int EXTRA_Z    = 2;
  localparam int EXTRA_C    = 3;
  localparam int NUM_EXTRAS = 4;

  // event slots in emission order: menu/joystick pairs (alt-fire joystick only), then extras
  localparam int NUM_SLOTS       = 19;
  localparam int SLOT_ALT_JOY    = 10;
  localparam int SLOT_START_MENU = 11;
  localparam int SLOT_START_JOY  = 12;
  localparam int SLOT_SEL_MENU   = 13;
  localparam int SLOT_SEL_JOY    = 14;
  localparam int SLOT_EXTRA_BASE = 15;

  typedef logic [NUM_SLOTS-1:0]  slot_vec_t;
  typedef logic [4:0]            event_code_t;
  typedef logic [NUM_CTRLS-1:0]  ctrl_vec_t;
  typedef logic [NUM_EXTRAS-1:0] extra_vec_t;

  localparam event_code_t FIRST_KBD_CODE = 5'd15;

  // event code carried by each slot
  localparam event_code_t SLOT_CODE [NUM_SLOTS] = '{
    5'd0,  5'd7,  5'd1,  5'd8,  5'd2,  5'd9,  5'd3,  5'd10,
    5'd4,  5'd11, 5'd12, 5'd5,  5'd13, 5'd6,  5'd14,
    5'd15, 5'd16, 5'd17, 5'd18
  };

endpackage

>>> rtl/core/grem_in_if.sv
// report input channel: valid/ready handshake with the report fields
`timescale 1ns / 1ps

interface grem_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] report_len;
  logic [7:0] x_axis;
  logic [7:0] y_axis;
  logic [7:0] face_byte;
  logic [7:0] button_byte;

  modport source (
    output valid, func, report_len, x_axis, y_axis, face_byte, button_byte,
    input  ready
  );

  modport sink (
    input  valid, func, report_len, x_axis, y_axis, face_byte, button_byte,
    output ready
  );
endinterface

>>> rtl/core/grem_out_if.sv
// event output channel: valid/ready handshake with the event fields
`timescale 1ns / 1ps

interface grem_out_if;
  logic                valid;
  logic                ready;
  grem_pkg::event_code_t event_code;
  logic                pressed;
  logic                to_keyboard_queue;
  logic                last;

  modport source (
    output valid, event_code, pressed, to_keyboard_queue, last,
    input  ready
  );

  modport sink (
    input  valid, event_code, pressed, to_keyboard_queue, last,
    output ready
  );
endinterface

>>> rtl/core/gamepad_report_event_mapper.sv
// gamepad report event mapper: report register, event slot register, event output register
`timescale 1ns / 1ps

// Gamepad report event mapper.
// rpt_in takes one report per transaction (layout, length, stick, face and
// button bytes). evt_out gives the press/release events that the report
// causes, one per transaction, with last set on the final one; a report that
// causes no event gives no transaction. cfg_wr_en/cfg_wr_data write the
// joystick suppress bit; write it only while the block is idle.
// Flow: a report passes from the report register through the event slot
// register to the output register. Events leave the output register one per
// cycle while evt_out does not stall, and the next report's events follow
// without a gap; a report causes at most 19 events. The report register takes
// a new report whenever it is empty, or the slot register is free or hands its
// last event to the output.
// Reset (rst, synchronous) clears the held controls, the per-layout extra
// button sets, the suppress bit and all valid flags. When evt_out stalls the
// output register holds its event, the slot register holds the rest, and
// rpt_in drops ready once the report register is full.

module gamepad_report_event_mapper (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  grem_in_if.sink    rpt_in,
  grem_out_if.source evt_out
);

  // configuration and kept state
  logic                  suppress;
  grem_pkg::ctrl_vec_t   held_controls;
  grem_pkg::extra_vec_t  extra_buttons_held [grem_pkg::NUM_LAYOUTS];

  // report register
  logic       rpt_valid;
  logic [1:0] rpt_func;
  logic [6:0] rpt_len;
  logic [7:0] rpt_x;
  logic [7:0] rpt_y;
  logic [7:0] rpt_face;
  logic [7:0] rpt_btn;

  // event slot register
  grem_pkg::slot_vec_t pending;
  grem_pkg::slot_vec_t pending_pressed;

  // output register
  logic                  out_valid;
  grem_pkg::event_code_t out_code;
  logic                  out_pressed;
  logic                  out_kbd;
  logic                  out_last;

  // decode signals
  logic                  fmt_ok;
  logic [3:0]            hat;
  grem_pkg::ctrl_vec_t   cur;
  grem_pkg::ctrl_vec_t   chg;
  grem_pkg::extra_vec_t  extras;
  grem_pkg::extra_vec_t  extras_prev;
  grem_pkg::extra_vec_t  extras_chg;
  grem_pkg::slot_vec_t   slot_en;
  grem_pkg::slot_vec_t   slot_pr;

  // serializer signals
  grem_pkg::slot_vec_t   sel;
  grem_pkg::slot_vec_t   rest;
  logic                  pend_last;
  logic                  load;
  logic                  xfer;
  grem_pkg::event_code_t sel_code;
  logic                  sel_pressed;

  // report decode: held controls and extra buttons
  always_comb begin
    fmt_ok = (rpt_func != grem_pkg::LAYOUT_UNUSED) &&
             (rpt_len >= ((rpt_func == grem_pkg::LAYOUT_HAT_B) ?
                          grem_pkg::MIN_LEN_LONG : grem_pkg::MIN_LEN_SHORT));
    hat = rpt_face[3:0];
    cur = '0;
    cur[grem_pkg::CTRL_UP]    = rpt_y < grem_pkg::AXIS_LOW;
    cur[grem_pkg::CTRL_DOWN]  = rpt_y > grem_pkg::AXIS_HIGH;
    cur[grem_pkg::CTRL_LEFT]  = rpt_x < grem_pkg::AXIS_LOW;
    cur[grem_pkg::CTRL_RIGHT] = rpt_x > grem_pkg::AXIS_HIGH;
    if (rpt_func == grem_pkg::LAYOUT_PLAIN) begin
      cur[grem_pkg::CTRL_FIRE] = rpt_face[6];
      cur[grem_pkg::CTRL_ALT]  = rpt_face[5];
    end else begin
      if (hat inside {grem_pkg::HAT_NW, grem_pkg::HAT_N, grem_pkg::HAT_NE}) begin
        cur[grem_pkg::CTRL_UP] = 1'b1;
      end
      if (hat inside {grem_pkg::HAT_NE, grem_pkg::HAT_E, grem_pkg::HAT_SE}) begin
        cur[grem_pkg::CTRL_RIGHT] = 1'b1;
      end
      if (hat inside {grem_pkg::HAT_SE, grem_pkg::HAT_S, grem_pkg::HAT_SW}) begin
        cur[grem_pkg::CTRL_DOWN] = 1'b1;
      end
      if (hat inside {grem_pkg::HAT_SW, grem_pkg::HAT_W, grem_pkg::HAT_NW}) begin
        cur[grem_pkg::CTRL_LEFT] = 1'b1;
      end
      cur[grem_pkg::CTRL_FIRE] = rpt_face[5];
      cur[grem_pkg::CTRL_ALT]  = rpt_face[6];
    end
    cur[grem_pkg::CTRL_START]  = rpt_btn[5];
    cur[grem_pkg::CTRL_SELECT] = rpt_btn[4];

    extras[grem_pkg::EXTRA_X] = rpt_face[4];
    extras[grem_pkg::EXTRA_Y] = rpt_face[7];
    extras[grem_pkg::EXTRA_Z] = rpt_btn[0];
    extras[grem_pkg::EXTRA_C] = rpt_btn[1];

    case (rpt_func)
      grem_pkg::LAYOUT_HAT_A: extras_prev = extra_buttons_held[1];
      grem_pkg::LAYOUT_HAT_B: extras_prev = extra_buttons_held[2];
      default:                extras_prev = extra_buttons_held[0];
    endcase

    chg        = cur ^ held_controls;
    extras_chg = extras ^ extras_prev;
  end

  // event slots: menu and joystick per changed control (alt-fire joystick only), then extras
  always_comb begin
    slot_en = '0;
    slot_pr = '0;
    for (int i = 0; i < grem_pkg::CTRL_ALT; i++) begin
      slot_en[2*i]   = chg[i];
      slot_en[2*i+1] = chg[i] && !suppress;
      slot_pr[2*i]   = cur[i];
      slot_pr[2*i+1] = cur[i];
    end
    // alt-fire has no menu event
    slot_en[grem_pkg::SLOT_ALT_JOY]    = chg[grem_pkg::CTRL_ALT] && !suppress;
    slot_pr[grem_pkg::SLOT_ALT_JOY]    = cur[grem_pkg::CTRL_ALT];
    slot_en[grem_pkg::SLOT_START_MENU] = chg[grem_pkg::CTRL_START];
    slot_pr[grem_pkg::SLOT_START_MENU] = cur[grem_pkg::CTRL_START];
    slot_en[grem_pkg::SLOT_START_JOY]  = chg[grem_pkg::CTRL_START] && !suppress;
    slot_pr[grem_pkg::SLOT_START_JOY]  = cur[grem_pkg::CTRL_START];
    slot_en[grem_pkg::SLOT_SEL_MENU]   = chg[grem_pkg::CTRL_SELECT];
    slot_pr[grem_pkg::SLOT_SEL_MENU]   = cur[grem_pkg::CTRL_SELECT];
    slot_en[grem_pkg::SLOT_SEL_JOY]    = chg[grem_pkg::CTRL_SELECT] && !suppress;
    slot_pr[grem_pkg::SLOT_SEL_JOY]    = cur[grem_pkg::CTRL_SELECT];
    for (int k = 0; k < grem_pkg::NUM_EXTRAS; k++) begin
      slot_en[grem_pkg::SLOT_EXTRA_BASE+k] = extras_chg[k];
      slot_pr[grem_pkg::SLOT_EXTRA_BASE+k] = extras[k];
    end
    // short report or unused layout gives nothing
    if (!fmt_ok) begin
      slot_en = '0;
    end
  end

  // pick the earliest pending slot
  always_comb begin
    sel         = pending & (~pending + 1'b1);
    rest        = pending & ~sel;
    pend_last   = (rest == '0);
    sel_code    = '0;
    sel_pressed = |(sel & pending_pressed);
    for (int j = 0; j < grem_pkg::NUM_SLOTS; j++) begin
      if (sel[j]) begin
        sel_code = sel_code | grem_pkg::SLOT_CODE[j];
      end
    end
  end

  // handshake control
  assign load         = (pending != '0) && (!out_valid || evt_out.ready);
  assign xfer         = rpt_valid && ((pending == '0) || (load && pend_last));
  assign rpt_in.ready = !rpt_valid || xfer;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      suppress <= 1'b0;
    end else if (cfg_wr_en) begin
      suppress <= cfg_wr_data;
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (rpt_in.valid && rpt_in.ready) begin
      rpt_valid <= 1'b1;
    end else if (xfer) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_in.valid && rpt_in.ready) begin
      rpt_func <= rpt_in.func;
      rpt_len  <= rpt_in.report_len;
      rpt_x    <= rpt_in.x_axis;
      rpt_y    <= rpt_in.y_axis;
      rpt_face <= rpt_in.face_byte;
      rpt_btn  <= rpt_in.button_byte;
    end
  end

  // kept state, updated when a well-formed report moves into the slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_controls <= '0;
      for (int l = 0; l < grem_pkg::NUM_LAYOUTS; l++) begin
        extra_buttons_held[l] <= '0;
      end
    end else if (xfer && fmt_ok) begin
      held_controls <= cur;
      case (rpt_func)
        grem_pkg::LAYOUT_HAT_A: extra_buttons_held[1] <= extras;
        grem_pkg::LAYOUT_HAT_B: extra_buttons_held[2] <= extras;
        default:                extra_buttons_held[0] <= extras;
      endcase
    end
  end

  // event slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (xfer) begin
      pending <= slot_en;
    end else if (load) begin
      pending <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      pending_pressed <= slot_pr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (evt_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code    <= sel_code;
      out_pressed <= sel_pressed;
      out_kbd     <= (sel_code >= grem_pkg::FIRST_KBD_CODE);
      out_last    <= pend_last;
    end
  end

  assign evt_out.valid             = out_valid;
  assign evt_out.event_code        = out_code;
  assign evt_out.pressed           = out_pressed;
  assign evt_out.to_keyboard_queue = out_kbd;
  assign evt_out.last              = out_last;

`ifndef ASSERT_OFF
  // pending events always reach the output register
  a_pending_moves: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |=> out_valid)
    else $error("pending events but output register empty");

  // an event that is not last is followed at once by another
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (evt_out.valid && evt_out.ready && !evt_out.last) |=> evt_out.valid)
    else $error("gap inside one report's events");

  // keyboard queue flag agrees with the extra event codes
  a_kbd_code: assert property (@(posedge clk) disable iff (rst)
    evt_out.valid |->
      (evt_out.to_keyboard_queue == (evt_out.event_code >= grem_pkg::FIRST_KBD_CODE)))
    else $error("keyboard queue flag does not match event code");
`endif

endmodule
